// ----- hw/rtl/itkp_pkg.sv -----
`default_nettype none

package itkp_pkg;

	localparam int NCAND_DEF         = 5;
	localparam int POSITION_BITS_DEF = 24;

	localparam int VAL_W     = 16;
	localparam int IDX_W     = 24;
	localparam int POS_OUT_W = 25;
	localparam int AMP_W     = 18;
	localparam int RANK_W    = 3;

	localparam logic [AMP_W-1:0] AMP_MAX = '1;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef struct packed {
		logic                    kind;
		logic signed [VAL_W-1:0] sample_value;
		logic [IDX_W-1:0]        interval_start;
		logic [IDX_W-1:0]        interval_stop;
	} in_t;

	typedef struct packed {
		logic signed [POS_OUT_W-1:0] candidate_position;
		logic [AMP_W-1:0]            relative_amplitude;
		logic [RANK_W-1:0]           candidate_rank;
		logic                        last_candidate;
	} out_t;

	// status handed from one cell to the next one down the list
	typedef struct packed {
		logic valid;
		logic ge;
	} link_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RECV,
		ST_PREP,
		ST_DIV,
		ST_LOAD
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/itkp_cell.sv -----
`default_nettype none

module itkp_cell #(
	parameter int PW = itkp_pkg::POSITION_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              clear,
	input  wire logic                              ins,
	input  wire logic signed [itkp_pkg::VAL_W-1:0] new_value,
	input  wire logic [PW-1:0]                     new_pos,
	input  wire itkp_pkg::link_t                   left,
	input  wire logic signed [itkp_pkg::VAL_W-1:0] left_value,
	input  wire logic [PW-1:0]                     left_pos,
	output itkp_pkg::link_t                        link,
	output logic signed [itkp_pkg::VAL_W-1:0]      value,
	output logic [PW-1:0]                          position
);
	import itkp_pkg::*;

	logic                    valid_q;
	logic signed [VAL_W-1:0] value_q;
	logic [PW-1:0]           pos_q;
	logic                    ge;
	logic                    take;

	// held entry stays put when it is at least the new sample (earlier wins ties)
	assign ge   = valid_q && (value_q >= new_value);
	assign take = ins && !ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= left.ge ? 1'b1 : left.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (left.ge) begin
				value_q <= new_value;
				pos_q   <= new_pos;
			end else begin
				value_q <= left_value;
				pos_q   <= left_pos;
			end
		end
	end

	assign link.valid = valid_q;
	assign link.ge    = ge;
	assign value      = value_q;
	assign position   = pos_q;

endmodule

`default_nettype wire

// ----- hw/rtl/itkp_div.sv -----
`default_nettype none

module itkp_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [15:0]                 num,
	input  wire logic [14:0]                 den,
	output logic                             busy,
	output logic [itkp_pkg::AMP_W-1:0]       amp
);
	import itkp_pkg::*;

	localparam int CNT_W = $clog2(AMP_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             sat_q;
	logic [15:0]      d_q;
	logic [15:0]      rem_q;
	logic [AMP_W-1:0] low_q;
	logic [AMP_W-1:0] quo_q;

	logic [15:0] d_init;
	logic [15:0] r_init;
	logic        over;
	logic [16:0] r_trial;
	logic [15:0] r_diff;
	logic        q_bit;

	// divide (num*2^17 + den) by 2*den, quotient limited to AMP_W bits
	assign d_init  = {den, 1'b0};
	assign r_init  = {1'b0, num[15:1]};
	assign over    = r_init >= d_init;
	assign r_trial = {rem_q, low_q[AMP_W-1]};
	// the difference is below the divisor whenever it is used
	assign r_diff  = r_trial[15:0] - d_q;
	assign q_bit   = r_trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !over;
			cnt_q  <= CNT_W'(AMP_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= over;
			d_q   <= d_init;
			rem_q <= r_init;
			low_q <= {num[0], 17'(den)};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= q_bit ? r_diff : r_trial[15:0];
			low_q <= {low_q[AMP_W-2:0], 1'b0};
			quo_q <= {quo_q[AMP_W-2:0], q_bit};
		end
	end

	assign busy = busy_q;
	assign amp  = sat_q ? AMP_MAX : quo_q;

endmodule

`default_nettype wire

// ----- hw/rtl/interval_top_k_peak_candidates_core.sv -----
// a sample is taken every cycle; after the last sample each rank passes through PREP, then the
// 18-step divider in DIV, then LOAD, which waits while an unaccepted result holds the output
// short or empty intervals, or a maximum not above zero: PREP then LOAD per rank, no division
// throughput: one input request per cycle while an interval streams in
// reset: arst_n low clears the state machine, cell valid bits, counters and output valid
`default_nettype none

module interval_top_k_peak_candidates_core #(
	parameter int NCAND         = itkp_pkg::NCAND_DEF,
	parameter int POSITION_BITS = itkp_pkg::POSITION_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire itkp_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output itkp_pkg::out_t      out_data
);
	import itkp_pkg::*;

	// stored positions never need more than the output field carries
	localparam int PW = (POSITION_BITS < POS_OUT_W) ? POSITION_BITS : POS_OUT_W;
	localparam int RW = (NCAND > 1) ? $clog2(NCAND) : 1;

	state_t state_q, state_d;

	// interval bookkeeping
	logic             empty_q;
	logic [IDX_W-1:0] base_q;
	logic [IDX_W-1:0] rem_q;
	logic [IDX_W-1:0] seen_q;
	logic [RW-1:0]    rank_q;

	// output register
	logic out_valid_q;
	out_t out_q;

	// handshake and control
	logic in_fire;
	logic is_header;
	logic is_empty;
	logic cell_clear;
	logic cell_ins;
	logic div_start;
	logic load_req;
	logic load;
	logic rank_last;

	// candidate chain
	link_t                   links    [NCAND];
	logic signed [VAL_W-1:0] cell_val [NCAND];
	logic [PW-1:0]           cell_pos [NCAND];
	logic [POS_OUT_W-1:0]    pos_sum;
	logic [PW-1:0]           sample_pos;

	// result selection
	logic                    full_mode;
	logic                    max_pos;
	logic [VAL_W-1:0]        diff;
	logic                    div_busy;
	logic [AMP_W-1:0]        div_amp;
	out_t                    res;

	assign in_fire   = in_valid && in_ready;
	assign is_header = (in_data.kind == KIND_HEADER);
	assign is_empty  = (in_data.interval_stop <= in_data.interval_start);
	assign rank_last = (rank_q == RW'(NCAND - 1));

	// absolute index of the incoming sample, wrapped to the stored width
	assign pos_sum    = POS_OUT_W'(base_q) + POS_OUT_W'(seen_q);
	assign sample_pos = PW'(pos_sum);

	assign cell_clear = in_fire && is_header;
	assign cell_ins   = in_fire && !is_header && (state_q == ST_RECV);

	// sorted list, largest at cell 0; each cell shifts down from its left neighbor
	for (genvar i = 0; i < NCAND; i++) begin : g_cell
		link_t                   left_link;
		logic signed [VAL_W-1:0] left_val;
		logic [PW-1:0]           left_pos;

		if (i == 0) begin : g_head
			assign left_link = '{valid: 1'b1, ge: 1'b1};
			assign left_val  = '0;
			assign left_pos  = '0;
		end else begin : g_body
			assign left_link = links[i-1];
			assign left_val  = cell_val[i-1];
			assign left_pos  = cell_pos[i-1];
		end

		itkp_cell #(.PW(PW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.clear      (cell_clear),
			.ins        (cell_ins),
			.new_value  (in_data.sample_value),
			.new_pos    (sample_pos),
			.left       (left_link),
			.left_value (left_val),
			.left_pos   (left_pos),
			.link       (links[i]),
			.value      (cell_val[i]),
			.position   (cell_pos[i])
		);
	end

	// full list means every rank is a real candidate with its own position (and amplitude when the maximum is positive)
	assign full_mode = !empty_q && links[NCAND-1].valid;
	assign max_pos   = (cell_val[0] > 0);
	// max minus value lies in 0..65535, so 16 bits hold it exactly
	assign diff      = cell_val[0] - cell_val[rank_q];

	itkp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (diff),
		.den    (cell_val[0][VAL_W-2:0]),
		.busy   (div_busy),
		.amp    (div_amp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE, ST_RECV: begin
				if (in_fire) begin
					if (is_header) begin
						state_d = is_empty ? ST_PREP : ST_RECV;
					end else if (state_q == ST_RECV && rem_q == '0) begin
						state_d = ST_PREP;
					end
				end
			end
			ST_PREP: begin
				state_d = (full_mode && max_pos) ? ST_DIV : ST_LOAD;
			end
			ST_DIV: begin
				if (!div_busy) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (load) begin
					state_d = rank_last ? ST_IDLE : ST_PREP;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		load_req  = 1'b0;
		unique case (state_q)
			ST_IDLE, ST_RECV: in_ready  = 1'b1;
			ST_PREP:          div_start = full_mode && max_pos;
			ST_DIV:           ;
			ST_LOAD:          load_req  = 1'b1;
			default:          ;
		endcase
	end

	assign load = load_req && (!out_valid_q || out_ready);

	// result for the current rank
	always_comb begin
		res.candidate_rank     = RANK_W'(rank_q);
		res.last_candidate     = rank_last;
		res.relative_amplitude = '0;
		if (empty_q) begin
			res.candidate_position = '1;
		end else if (full_mode) begin
			res.candidate_position = POS_OUT_W'(cell_pos[rank_q]);
			if (max_pos) begin
				res.relative_amplitude = div_amp;
			end
		end else begin
			// short interval: every rank points at the first maximum
			res.candidate_position = POS_OUT_W'(cell_pos[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			empty_q     <= 1'b0;
			base_q      <= '0;
			rem_q       <= '0;
			seen_q      <= '0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (in_fire) begin
				rank_q <= '0;
				if (is_header) begin
					// a header while receiving drops the interval in progress
					empty_q <= is_empty;
					seen_q  <= '0;
					if (is_empty) begin
						rem_q <= '0;
					end else begin
						base_q <= in_data.interval_start;
						rem_q  <= in_data.interval_stop - in_data.interval_start;
					end
				end else if (state_q == ST_RECV) begin
					seen_q <= seen_q + IDX_W'(1);
					if (rem_q != '0) begin
						rem_q <= rem_q - IDX_W'(1);
					end
				end
			end else if (load) begin
				rank_q <= rank_last ? '0 : rank_q + RW'(1);
			end

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/itkp_checker.sv -----
`default_nettype none

module itkp_checker #(
	parameter int NCAND = itkp_pkg::NCAND_DEF
) (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire itkp_pkg::out_t out_data
);
	import itkp_pkg::*;

	// pending result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// final flag only on the last rank
	a_last_rank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_candidate |->
			out_data.candidate_rank == RANK_W'(NCAND - 1))
		else $error("last flag on wrong rank");

	// no new request taken while an interval still has results to deliver
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_candidate |-> !(in_valid && in_ready))
		else $error("input accepted mid result burst");

	// the top candidate is its own maximum
	a_rank0_amp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.candidate_rank == '0 |-> out_data.relative_amplitude == '0)
		else $error("rank zero amplitude not zero");

	// empty interval carries no amplitude
	a_empty_amp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.candidate_position == '1 |->
			out_data.relative_amplitude == '0)
		else $error("empty interval with amplitude");

endmodule

bind interval_top_k_peak_candidates_core itkp_checker #(.NCAND(NCAND)) u_itkp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ----- dv/peak_candidate_checker.sv -----
`default_nettype none

module peak_candidate_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_ready,
	input  wire itkp_pkg::in_t  in_data,
	input  wire logic           out_valid,
	input  wire logic           out_ready,
	input  wire itkp_pkg::out_t out_data,
	output int                  mismatches,
	output int                  outstanding,
	output int                  checked
);

	timeunit 1ns;
	timeprecision 1ps;

	import itkp_pkg::*;

	localparam int NCAND = NCAND_DEF;

	// sorted candidate list of the interval in progress
	logic signed [VAL_W-1:0] best_val [NCAND];
	logic [IDX_W-1:0]        best_pos [NCAND];
	int unsigned             filled;
	logic [IDX_W-1:0]        base;
	logic [IDX_W-1:0]        remaining;
	logic [IDX_W-1:0]        seen;
	bit                      busy;

	out_t expected_candidates [$];
	out_t want;
	int   errs;
	int   done;

	function automatic logic [AMP_W-1:0] relative_amplitude(input int value, input int peak);
		longint unsigned num, den, q;
		if (peak <= 0)
			return '0;
		num = longint'(peak - value);
		den = longint'(peak);
		q   = (num * 131072 + den) / (2 * den);
		if (q > AMP_MAX)
			q = AMP_MAX;
		return q[AMP_W-1:0];
	endfunction

	function automatic out_t make_candidate(input int rank, input logic signed [POS_OUT_W-1:0] pos,
			input logic [AMP_W-1:0] amp);
		out_t c;
		c.candidate_position = pos;
		c.relative_amplitude = amp;
		c.candidate_rank     = rank[RANK_W-1:0];
		c.last_candidate     = (rank == NCAND - 1);
		return c;
	endfunction

	// append one expected result at the tail of the queue
	task automatic queue_candidate(input out_t c);
		expected_candidates.insert(expected_candidates.size(), c);
	endtask

	task automatic track_request(input in_t req);
		logic [IDX_W-1:0] pos;
		int               slot;
		if (req.kind == KIND_HEADER) begin
			filled = 0;
			seen   = '0;
			if (req.interval_stop <= req.interval_start) begin
				// empty interval answers at once
				busy      = 1'b0;
				remaining = '0;
				for (int r = 0; r < NCAND; r++)
					queue_candidate(make_candidate(r, '1, '0));
			end else begin
				base      = req.interval_start;
				remaining = req.interval_stop - req.interval_start;
				busy      = 1'b1;
			end
		end else if (busy) begin
			pos  = base + seen;
			slot = 0;
			while (slot < filled && best_val[slot] >= req.sample_value)
				slot++;
			if (slot < NCAND) begin
				for (int i = (filled < NCAND) ? filled : NCAND - 1; i > slot; i--) begin
					best_val[i] = best_val[i-1];
					best_pos[i] = best_pos[i-1];
				end
				best_val[slot] = req.sample_value;
				best_pos[slot] = pos;
				if (filled < NCAND)
					filled++;
			end
			seen = seen + 1'b1;
			if (remaining != 0) begin
				remaining = remaining - 1'b1;
			end else begin
				busy = 1'b0;
				for (int r = 0; r < NCAND; r++) begin
					if (filled < NCAND)
						queue_candidate(make_candidate(r, {1'b0, best_pos[0]}, '0));
					else
						queue_candidate(make_candidate(r, {1'b0, best_pos[r]},
							relative_amplitude(best_val[r], best_val[0])));
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled    = 0;
			base      = '0;
			remaining = '0;
			seen      = '0;
			busy      = 1'b0;
			errs      = 0;
			done      = 0;
			expected_candidates.delete();
			mismatches  <= 0;
			outstanding <= 0;
			checked     <= 0;
		end else begin
			if (in_valid && in_ready)
				track_request(in_data);
			if (out_valid && out_ready) begin
				if (expected_candidates.size() == 0) begin
					$error("candidate with no request behind it: position %0d rank %0d",
						out_data.candidate_position, out_data.candidate_rank);
					errs++;
				end else begin
					want = expected_candidates.pop_front();
					done++;
					if (out_data.candidate_position !== want.candidate_position) begin
						$error("candidate_position expected %0d got %0d",
							want.candidate_position, out_data.candidate_position);
						errs++;
					end
					if (out_data.relative_amplitude !== want.relative_amplitude) begin
						$error("relative_amplitude expected %0d got %0d",
							want.relative_amplitude, out_data.relative_amplitude);
						errs++;
					end
					if (out_data.candidate_rank !== want.candidate_rank) begin
						$error("candidate_rank expected %0d got %0d",
							want.candidate_rank, out_data.candidate_rank);
						errs++;
					end
					if (out_data.last_candidate !== want.last_candidate) begin
						$error("last_candidate expected %0d got %0d",
							want.last_candidate, out_data.last_candidate);
						errs++;
					end
				end
			end
			mismatches  <= errs;
			outstanding <= expected_candidates.size();
			checked     <= done;
		end
	end

endmodule

`default_nettype wire

// ----- dv/tb_interval_top_k_peak_candidates_core.sv -----
`default_nettype none

module tb_interval_top_k_peak_candidates_core;

	timeunit 1ns;
	timeprecision 1ps;

	import itkp_pkg::*;

	localparam int TARGET_REQUESTS = 410;
	localparam int HOLD_CYCLES     = 500;   // long receiver hold-off to back the block up
	localparam int QUIET_LIMIT     = 4000;  // cycles with no handshake before giving up
	localparam int DRAIN_CYCLES    = 60;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	int mismatches;
	int outstanding;
	int checked;

	// stimulus bookkeeping
	int headers = 0;
	int samples = 0;
	int strays  = 0;
	int burst_left = 0;
	int quiet_cycles = 0;
	bit stall_hold_req = 1'b0;
	bit stall_hold_done = 1'b0;

	interval_top_k_peak_candidates_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	peak_candidate_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// header request; the sample field is don't-care so it gets random bits
	function automatic in_t header_req(input logic [IDX_W-1:0] start, input logic [IDX_W-1:0] stop);
		in_t req;
		req.kind           = KIND_HEADER;
		req.sample_value   = VAL_W'($urandom);
		req.interval_start = start;
		req.interval_stop  = stop;
		return req;
	endfunction

	// sample request; the interval fields are don't-care so they get random bits
	function automatic in_t sample_req(input logic signed [VAL_W-1:0] v);
		in_t req;
		req.kind           = KIND_SAMPLE;
		req.sample_value   = v;
		req.interval_start = IDX_W'($urandom);
		req.interval_stop  = IDX_W'($urandom);
		return req;
	endfunction

	// offer one request; starts and ends at a falling edge
	// the sender runs in bursts, with a random gap (sometimes none) between bursts
	task automatic send(input in_t req);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 16);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= req;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// header plus nsamples samples of an interval holding len samples;
	// nsamples < len leaves the interval open so the next header abandons it
	task automatic run_interval(input int len, input int nsamples);
		logic [IDX_W-1:0]        start;
		int                      hi;
		int                      mode;
		logic signed [VAL_W-1:0] v;
		hi = 24'hffffff - (len - 1);
		// now and then push the interval right against the top of the index range
		start = ($urandom_range(0, 7) == 0) ? IDX_W'(hi - int'($urandom_range(0, 3))) :
			IDX_W'($urandom_range(0, hi));
		send(header_req(start, start + IDX_W'(len - 1)));
		headers++;
		mode = $urandom_range(0, 3);
		for (int k = 0; k < nsamples; k++) begin
			case (mode)
				0: v = VAL_W'($urandom);
				// narrow spread: lots of ties, often a non-positive maximum
				1: v = VAL_W'(int'($urandom_range(0, 6)) - 3);
				// extremes of the sample range
				2: case ($urandom_range(0, 5))
					0: v = 16'sh7fff;
					1: v = 16'sh8000;
					2: v = 16'sh7ffe;
					3: v = 16'sd1;
					4: v = 16'sd0;
					default: v = -16'sd1;
				endcase
				default: v = VAL_W'(int'($urandom_range(0, 40000)) - 7232);
			endcase
			send(sample_req(v));
			samples++;
		end
	endtask

	// receiver: stall pattern that changes mode every so often, plus one long hold-off
	initial begin
		int mode;
		int left;
		left = 0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_hold_req && !stall_hold_done) begin
				// hold off while the sender keeps offering, so the block backs up
				stall_hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 2);
					left = $urandom_range(20, 200);
				end
				left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// watchdog: too long with nothing accepted on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("interval_top_k_peak_candidates_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		int          pick;
		int          shape;
		int          len;
		int          intervals;
		bit          block_idle;
		logic [23:0] a;
		intervals  = 0;
		block_idle = 1'b1;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: a sample with no interval open is dropped
		send(sample_req(16'sh1234));
		strays++;
		// empty intervals: stop equal to start, and stop below start
		send(header_req(24'h000000, 24'h000000));
		send(header_req(24'hffffff, 24'h000000));
		headers += 2;
		// two-sample interval: fewer than five, so first maximum and zero amplitude
		send(header_req(24'd10, 24'd11));
		send(sample_req(16'sh7fff));
		send(sample_req(16'sh8000));
		headers++;
		samples += 2;
		// top of the index range, tied maxima, large amplitudes against a peak of 1
		send(header_req(24'hfffffa, 24'hffffff));
		send(sample_req(16'sd1));
		send(sample_req(16'sh8000));
		send(sample_req(16'sd1));
		send(sample_req(16'sd0));
		send(sample_req(16'sd1));
		send(sample_req(-16'sd1));
		headers++;
		samples += 6;
		// all negative with ties: maximum not positive, so every amplitude is zero
		send(header_req(24'd0, 24'd4));
		send(sample_req(-16'sd5));
		send(sample_req(-16'sd1));
		send(sample_req(-16'sd1));
		send(sample_req(16'sh8000));
		send(sample_req(-16'sd3));
		headers++;
		samples += 5;
		// a new header in mid-interval abandons it; the new one then completes
		send(header_req(24'd20, 24'd30));
		send(sample_req(16'sd100));
		send(sample_req(16'sd200));
		send(header_req(24'd40, 24'd44));
		send(sample_req(16'sh7fff));
		send(sample_req(16'sh8000));
		send(sample_req(16'sh0001));
		send(sample_req(16'sh7fff));
		send(sample_req(16'sh4000));
		headers += 2;
		samples += 7;

		// random: mostly complete intervals, some empty, abandoned or stray requests
		while (headers + samples < TARGET_REQUESTS) begin
			if (intervals == 12)
				stall_hold_req = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				a = IDX_W'($urandom_range(0, 24'hffffff));
				send(header_req(a, IDX_W'($urandom_range(0, a))));
				headers++;
				block_idle = 1'b1;
			end else if (pick < 12 && block_idle) begin
				repeat ($urandom_range(1, 3)) begin
					send(sample_req(VAL_W'($urandom)));
					strays++;
				end
			end else begin
				shape = $urandom_range(0, 99);
				if (shape < 12)
					len = $urandom_range(2, 4);
				else if (shape < 92)
					len = $urandom_range(5, 16);
				else
					len = $urandom_range(17, 48);
				if (pick < 20) begin
					run_interval(len, $urandom_range(0, len - 1));
					block_idle = 1'b0;
				end else begin
					run_interval(len, len);
					block_idle = 1'b1;
				end
			end
			intervals++;
		end
		in_valid <= 1'b0;

		// drain: the watchdog catches results that never come
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d headers and %0d samples (%0d dropped while idle),",
			headers, samples, strays);
		$display("with %0d candidate results checked and %0d mismatches", checked, mismatches);
		if (mismatches == 0)
			$display("interval_top_k_peak_candidates_core verification clean");
		else
			$display("interval_top_k_peak_candidates_core verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/itkp_pkg.sv
hw/rtl/itkp_cell.sv
hw/rtl/itkp_div.sv
hw/rtl/interval_top_k_peak_candidates_core.sv
hw/rtl/itkp_checker.sv
dv/peak_candidate_checker.sv
dv/tb_interval_top_k_peak_candidates_core.sv
